[design/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

   // per-corner axis offsets, bit k belongs to corner k
   // corner order by xyz offset: 000, 100, 010, 001, 110, 011, 101, 111
   localparam logic [7:0] CORNER_DX = 8'b1101_0010;
   localparam logic [7:0] CORNER_DY = 8'b1011_0100;
   localparam logic [7:0] CORNER_DZ = 8'b1110_1000;

   localparam int CORNER_BITS = 3;
   localparam logic [CORNER_BITS-1:0] FIRST_CORNER = 3'd0;
   localparam logic [CORNER_BITS-1:0] LAST_CORNER  = 3'd7;

   localparam int POS_BITS    = 32;
   localparam int COORD_BITS  = 17;
   localparam int WEIGHT_BITS = 17;

   typedef logic [CORNER_BITS-1:0] corner_type;
   typedef logic signed [COORD_BITS-1:0] coord_type;

endpackage

`default_nettype wire

[design/trilinear_corner_weights_unit.sv]
`default_nettype none

// channel   | ports                                   | handshake
// ----------+-----------------------------------------+----------------------------------
// request   | req_pos_x, req_pos_y, req_pos_z         | beat taken when start && !busy
// response  | rsp_corner_index, rsp_corner_x/y/z,     | rsp_valid strobe, one beat per
//           | rsp_weight, rsp_last                    | cycle, receiver cannot stall
//
// each position yields eight response beats, one per cycle, and the next position can be
// taken in the cycle its last corner issues, while earlier corners are still in flight;
// the single response port and the corner sequencer set that pace. each corner passes
// stage 1, stage 2, stage 3 and the response register in turn. reset (synchronous,
// active high) drops the held position and all stage valid bits. the pipeline never
// stalls: the receiver cannot hold beats off, and busy only covers the corner sequencer.

module trilinear_corner_weights_unit #(
   parameter int FRAC_BITS = 16,
   parameter int INT_BITS  = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      start,
   output      logic                                      busy,
   input  wire logic signed [tcw_pkg::POS_BITS-1:0]       req_pos_x,
   input  wire logic signed [tcw_pkg::POS_BITS-1:0]       req_pos_y,
   input  wire logic signed [tcw_pkg::POS_BITS-1:0]       req_pos_z,
   output      logic                                      rsp_valid,
   output      tcw_pkg::corner_type                       rsp_corner_index,
   output      tcw_pkg::coord_type                        rsp_corner_x,
   output      tcw_pkg::coord_type                        rsp_corner_y,
   output      tcw_pkg::coord_type                        rsp_corner_z,
   output      logic [tcw_pkg::WEIGHT_BITS-1:0]           rsp_weight,
   output      logic                                      rsp_last
);

   // factor width: Q0.FRAC_BITS plus one bit so that exactly one fits
   localparam int FW  = FRAC_BITS + 1;
   localparam int PW  = 2 * FW;              // first product
   localparam int HW  = PW - FRAC_BITS;      // upper part of first product
   localparam int PHW = HW + FW;             // upper partial product
   localparam int PLW = FRAC_BITS + FW;      // lower partial product
   localparam int SW  = PHW + 1;             // final sum
   localparam int CB  = INT_BITS + 1;        // corner wrap width
   localparam int EW  = tcw_pkg::POS_BITS + 2;
   localparam logic [FW-1:0] ONE_Q = FW'(1) << FRAC_BITS;

   // per-axis factor: frac when offset is one, else one minus frac
   function automatic logic [FW-1:0] factor_of(input logic [tcw_pkg::POS_BITS-1:0] pos,
                                               input logic d);
      logic [FW-1:0] f;
      f = {1'b0, pos[FRAC_BITS-1:0]};
      return d ? f : (ONE_Q - f);
   endfunction

   // floor plus offset, wrapped to INT_BITS+1 bits, then cut to the field
   function automatic tcw_pkg::coord_type corner_of(
         input logic [tcw_pkg::POS_BITS-1:0] pos, input logic d);
      logic signed [EW-1:0] ext;
      logic signed [EW-1:0] flo;
      logic        [EW-1:0] sum;
      logic        [EW-1:0] wrapped;
      ext     = {{2{pos[tcw_pkg::POS_BITS-1]}}, pos};
      flo     = ext >>> FRAC_BITS;
      sum     = flo + {{(EW-1){1'b0}}, d};
      wrapped = {{(EW-CB){sum[CB-1]}}, sum[CB-1:0]};
      return wrapped[tcw_pkg::COORD_BITS-1:0];
   endfunction

   // corner sequencer: holds one position and walks its eight corners
   logic [tcw_pkg::POS_BITS-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic                         hold_valid_ff, hold_valid_in;
   tcw_pkg::corner_type          corner_ff, corner_in;
   logic                         accept;

   // can take the next position in the cycle the last corner issues
   assign busy   = hold_valid_ff && (corner_ff != tcw_pkg::LAST_CORNER);
   assign accept = start && !busy;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      corner_in     = corner_ff;
      if (hold_valid_ff) begin
         corner_in = corner_ff + 3'd1;
         if (corner_ff == tcw_pkg::LAST_CORNER) begin
            hold_valid_in = 1'b0;
         end
      end
      if (accept) begin
         hold_valid_in = 1'b1;
         corner_in     = tcw_pkg::FIRST_CORNER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         corner_ff     <= tcw_pkg::FIRST_CORNER;
      end else begin
         hold_valid_ff <= hold_valid_in;
         corner_ff     <= corner_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
         pos_z_ff <= req_pos_z;
      end
   end

   // stage 1: split position, pick factors, form corner coordinates
   logic                 s1_valid_ff;
   logic [FW-1:0]        s1_wx_ff, s1_wy_ff, s1_wz_ff;
   tcw_pkg::coord_type   s1_cx_ff, s1_cy_ff, s1_cz_ff;
   tcw_pkg::corner_type  s1_idx_ff;

   // stage 2: first product wx * wy
   logic                 s2_valid_ff;
   logic [PW-1:0]        s2_ab_ff;
   logic [FW-1:0]        s2_wz_ff;
   tcw_pkg::coord_type   s2_cx_ff, s2_cy_ff, s2_cz_ff;
   tcw_pkg::corner_type  s2_idx_ff;

   // stage 3: upper and lower partial products with wz
   logic                 s3_valid_ff;
   logic [PHW-1:0]       s3_phi_ff;
   logic [PLW-1:0]       s3_plo_ff;
   tcw_pkg::coord_type   s3_cx_ff, s3_cy_ff, s3_cz_ff;
   tcw_pkg::corner_type  s3_idx_ff;

   logic dx, dy, dz;
   assign dx = tcw_pkg::CORNER_DX[corner_ff];
   assign dy = tcw_pkg::CORNER_DY[corner_ff];
   assign dz = tcw_pkg::CORNER_DZ[corner_ff];

   logic [HW-1:0]        ab_hi;
   logic [FRAC_BITS-1:0] ab_lo;
   assign ab_hi = s2_ab_ff[PW-1:FRAC_BITS];
   assign ab_lo = s2_ab_ff[FRAC_BITS-1:0];

   // stage 4: exact floor of the triple product, hi*c plus carried lower part
   logic [SW-1:0] w_sum;
   logic [SW-1:0] w_shift;
   logic [63:0]   w_full;
   assign w_sum   = SW'(s3_phi_ff) + SW'(s3_plo_ff >> FRAC_BITS);
   assign w_shift = w_sum >> FRAC_BITS;
   assign w_full  = 64'(w_shift);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
      end else begin
         s1_valid_ff <= hold_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         rsp_valid   <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_wx_ff  <= factor_of(pos_x_ff, dx);
      s1_wy_ff  <= factor_of(pos_y_ff, dy);
      s1_wz_ff  <= factor_of(pos_z_ff, dz);
      s1_cx_ff  <= corner_of(pos_x_ff, dx);
      s1_cy_ff  <= corner_of(pos_y_ff, dy);
      s1_cz_ff  <= corner_of(pos_z_ff, dz);
      s1_idx_ff <= corner_ff;

      s2_ab_ff  <= PW'(s1_wx_ff) * PW'(s1_wy_ff);
      s2_wz_ff  <= s1_wz_ff;
      s2_cx_ff  <= s1_cx_ff;
      s2_cy_ff  <= s1_cy_ff;
      s2_cz_ff  <= s1_cz_ff;
      s2_idx_ff <= s1_idx_ff;

      s3_phi_ff <= PHW'(ab_hi) * PHW'(s2_wz_ff);
      s3_plo_ff <= PLW'(ab_lo) * PLW'(s2_wz_ff);
      s3_cx_ff  <= s2_cx_ff;
      s3_cy_ff  <= s2_cy_ff;
      s3_cz_ff  <= s2_cz_ff;
      s3_idx_ff <= s2_idx_ff;

      // response register drives the ports directly
      rsp_weight       <= w_full[tcw_pkg::WEIGHT_BITS-1:0];
      rsp_corner_x     <= s3_cx_ff;
      rsp_corner_y     <= s3_cy_ff;
      rsp_corner_z     <= s3_cz_ff;
      rsp_corner_index <= s3_idx_ff;
      rsp_last         <= (s3_idx_ff == tcw_pkg::LAST_CORNER);
   end

endmodule

`default_nettype wire

[bench/tb.sv]
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // block parameters, kept at the defaults
   localparam int FRAC_W   = 16;
   localparam int INT_W    = 16;
   localparam int CORNER_W = INT_W + 1;

   // port widths taken from the package
   localparam int POS_W    = tcw_pkg::POS_BITS;
   localparam int COORD_W  = tcw_pkg::COORD_BITS;
   localparam int WEIGHT_W = tcw_pkg::WEIGHT_BITS;
   localparam int IDX_W    = tcw_pkg::CORNER_BITS;

   localparam int N_RANDOM   = 460;
   localparam int QUIET_FROM = 150;   // random items in [QUIET_FROM, QUIET_TO) never idle
   localparam int QUIET_TO   = 290;
   localparam int HOLD_AT    = 320;   // sender holds off here until all beats are back
   localparam int DRAIN_MAX  = 400;   // cycles allowed for the last beats to arrive
   localparam int TAIL       = 16;    // margin after the drain for a stray late beat

   // axis offsets per corner, corner 0 leftmost: 000,100,010,001,110,011,101,111
   localparam logic [0:7] STEP_X = 8'b0100_1011;
   localparam logic [0:7] STEP_Y = 8'b0010_1101;
   localparam logic [0:7] STEP_Z = 8'b0001_0111;

   localparam longint unsigned ONE_Q     = 64'd1 << FRAC_W;
   localparam longint unsigned FRAC_MASK = ONE_Q - 1;

   typedef struct packed {
      tcw_pkg::corner_type          idx;
      tcw_pkg::coord_type           cx;
      tcw_pkg::coord_type           cy;
      tcw_pkg::coord_type           cz;
      logic [WEIGHT_W-1:0]          w;
      logic                         last;
   } corner_beat_type;

   // one stimulus row; where on_grid is set the corners are typed in by hand
   typedef struct {
      logic signed [POS_W-1:0]      x;
      logic signed [POS_W-1:0]      y;
      logic signed [POS_W-1:0]      z;
      bit                           on_grid;
      int                           fx;
      int                           fy;
      int                           fz;
   } pos_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic signed [POS_W-1:0]         req_pos_x = '0;
   logic signed [POS_W-1:0]         req_pos_y = '0;
   logic signed [POS_W-1:0]         req_pos_z = '0;
   logic                            rsp_valid;
   tcw_pkg::corner_type             rsp_corner_index;
   tcw_pkg::coord_type              rsp_corner_x;
   tcw_pkg::coord_type              rsp_corner_y;
   tcw_pkg::coord_type              rsp_corner_z;
   logic [WEIGHT_W-1:0]             rsp_weight;
   logic                            rsp_last;

   // row currently on the request ports, driven together with the data
   pos_row_type                     cur_row;

   corner_beat_type                 corner_q[$];
   pos_row_type                     directed_rows[$];
   bit                              quiet;

   int                              n_errors   = 0;
   int                              n_pos      = 0;
   int                              n_beats    = 0;
   int                              n_grid     = 0;
   int                              n_negative = 0;

   trilinear_corner_weights_unit #(
      .FRAC_BITS(FRAC_W),
      .INT_BITS (INT_W)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .rsp_valid       (rsp_valid),
      .rsp_corner_index(rsp_corner_index),
      .rsp_corner_x    (rsp_corner_x),
      .rsp_corner_y    (rsp_corner_y),
      .rsp_corner_z    (rsp_corner_z),
      .rsp_weight      (rsp_weight),
      .rsp_last        (rsp_last)
   );

   always #1 clock = ~clock;

   // hard stop, far beyond the slowest legal run
   initial begin
      #200us;
      $display("tb: done, errors");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("tb: mismatch %s got %0h want %0h (beat %0d)", what, got, want, n_beats);
      n_errors++;
   endtask

   // corner coordinate wrapped to INT_W+1 bits, then cut to the port
   function automatic tcw_pkg::coord_type wrap_coord(input longint v);
      longint w;
      w = (v <<< (64 - CORNER_W)) >>> (64 - CORNER_W);
      return w[COORD_W-1:0];
   endfunction

   // floor(a*b*c / 2^(2*FRAC_W)) without overflowing 64 bits
   function automatic longint unsigned tri_weight(input longint unsigned a,
                                                  input longint unsigned b,
                                                  input longint unsigned c);
      longint unsigned ab;
      longint unsigned hi;
      longint unsigned lo;
      ab = a * b;
      hi = ab >> FRAC_W;
      lo = ab & FRAC_MASK;
      return (hi * c + ((lo * c) >> FRAC_W)) >> FRAC_W;
   endfunction

   // queue the eight corner beats of one position
   function automatic void predict_corners(input logic signed [POS_W-1:0] px,
                                           input logic signed [POS_W-1:0] py,
                                           input logic signed [POS_W-1:0] pz);
      longint          flx, fly, flz;
      longint unsigned frx, fry, frz;
      longint unsigned wx, wy, wz;
      corner_beat_type b;
      // arithmetic shift is floor, the low bits are the fraction in [0,1)
      flx = longint'(px) >>> FRAC_W;
      fly = longint'(py) >>> FRAC_W;
      flz = longint'(pz) >>> FRAC_W;
      frx = longint'(px) & FRAC_MASK;
      fry = longint'(py) & FRAC_MASK;
      frz = longint'(pz) & FRAC_MASK;
      for (int k = 0; k < 8; k++) begin
         wx     = STEP_X[k] ? frx : ONE_Q - frx;
         wy     = STEP_Y[k] ? fry : ONE_Q - fry;
         wz     = STEP_Z[k] ? frz : ONE_Q - frz;
         b.idx  = IDX_W'(k);
         b.cx   = wrap_coord(flx + longint'(STEP_X[k]));
         b.cy   = wrap_coord(fly + longint'(STEP_Y[k]));
         b.cz   = wrap_coord(flz + longint'(STEP_Z[k]));
         b.w    = WEIGHT_W'(tri_weight(wx, wy, wz));
         b.last = (k == 7);
         corner_q.push_back(b);
      end
   endfunction

   // grid point read off by hand: corner 000 carries all the weight
   function automatic void queue_grid_corners(input pos_row_type r);
      corner_beat_type b;
      for (int k = 0; k < 8; k++) begin
         b.idx  = IDX_W'(k);
         b.cx   = COORD_W'(r.fx + int'(STEP_X[k]));
         b.cy   = COORD_W'(r.fy + int'(STEP_Y[k]));
         b.cz   = COORD_W'(r.fz + int'(STEP_Z[k]));
         b.w    = (k == 0) ? WEIGHT_W'(ONE_Q) : '0;
         b.last = (k == 7);
         corner_q.push_back(b);
      end
   endfunction

   // one position coordinate, biased toward the interesting corners of the range
   function automatic logic signed [POS_W-1:0] rand_coord();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(9))
         5, 6: return POS_W'(int'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000);
         7:    return {r[31:16], 16'h0000};                     // on the grid
         8:    return {r[31] ? 16'h7FFF : 16'h8000, r[15:0]};   // near the extremes
         9: begin
            case (r[1:0])
               2'd0:    return {r[31:16], 16'h0001};
               2'd1:    return {r[31:16], 16'hFFFF};
               2'd2:    return {r[31:16], 16'h8000};
               default: return {r[31:16], 16'h7FFF};
            endcase
         end
         default: return r;
      endcase
   endfunction

   function automatic pos_row_type pos_row(input logic [31:0] x, input logic [31:0] y,
                                           input logic [31:0] z);
      pos_row_type r;
      r.x       = x;
      r.y       = y;
      r.z       = z;
      r.on_grid = 1'b0;
      r.fx      = 0;
      r.fy      = 0;
      r.fz      = 0;
      return r;
   endfunction

   function automatic pos_row_type grid_row(input int fx, input int fy, input int fz);
      pos_row_type r;
      r.x       = POS_W'(fx) << FRAC_W;
      r.y       = POS_W'(fy) << FRAC_W;
      r.z       = POS_W'(fz) << FRAC_W;
      r.on_grid = 1'b1;
      r.fx      = fx;
      r.fy      = fy;
      r.fz      = fz;
      return r;
   endfunction

   // response check and prediction, both on the rising edge
   always @(posedge clock) begin : beat_monitor
      corner_beat_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (corner_q.size() == 0) begin
               report_mismatch("unexpected beat, corner", rsp_corner_index, 0);
            end else begin
               want = corner_q.pop_front();
               if (rsp_corner_index !== want.idx)
                  report_mismatch("corner_index", rsp_corner_index, want.idx);
               if (rsp_corner_x !== want.cx) report_mismatch("corner_x", rsp_corner_x, want.cx);
               if (rsp_corner_y !== want.cy) report_mismatch("corner_y", rsp_corner_y, want.cy);
               if (rsp_corner_z !== want.cz) report_mismatch("corner_z", rsp_corner_z, want.cz);
               if (rsp_weight !== want.w)    report_mismatch("weight", rsp_weight, want.w);
               if (rsp_last !== want.last)   report_mismatch("last", rsp_last, want.last);
               n_beats++;
            end
         end
         // request beat taken on this edge
         if (start && !busy) begin
            if (cur_row.on_grid)
               queue_grid_corners(cur_row);
            else
               predict_corners(req_pos_x, req_pos_y, req_pos_z);
            n_pos++;
            if (req_pos_x[FRAC_W-1:0] == 0 && req_pos_y[FRAC_W-1:0] == 0 &&
                req_pos_z[FRAC_W-1:0] == 0)
               n_grid++;
            if (req_pos_x[POS_W-1] || req_pos_y[POS_W-1] || req_pos_z[POS_W-1])
               n_negative++;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the accept
   task automatic send_position(input pos_row_type r);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(99) < 17) gap = $urandom_range(1, 12);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start     <= 1'b1;
      req_pos_x <= r.x;
      req_pos_y <= r.y;
      req_pos_z <= r.z;
      cur_row   <= r;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // sender backs off until every queued corner has come out
   task automatic hold_until_drained();
      start <= 1'b0;
      @(negedge clock);
      while (corner_q.size() != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int          waited;
      pos_row_type r;

      cur_row = pos_row(0, 0, 0);
      quiet   = 1'b0;

      // directed table: grid points typed in, the rest go through the predictor
      directed_rows.push_back(grid_row(0, 0, 0));
      directed_rows.push_back(grid_row(1, 2, 3));
      directed_rows.push_back(grid_row(-1, -1, -1));
      directed_rows.push_back(grid_row(-32768, -32768, -32768));
      directed_rows.push_back(grid_row(32767, 32767, 32767));
      directed_rows.push_back(grid_row(-32768, 0, 32767));
      directed_rows.push_back(pos_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      directed_rows.push_back(pos_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000));
      directed_rows.push_back(pos_row(32'h8000_0001, 32'h8000_0001, 32'h8000_0001));
      directed_rows.push_back(pos_row(32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
      directed_rows.push_back(pos_row(32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000));
      directed_rows.push_back(pos_row(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
      directed_rows.push_back(pos_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      directed_rows.push_back(pos_row(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF));
      directed_rows.push_back(pos_row(32'h0000_4000, 32'h0000_0000, 32'h0000_0000));
      directed_rows.push_back(pos_row(32'h0000_0000, 32'h0000_C000, 32'h0000_0000));
      directed_rows.push_back(pos_row(32'h0000_0000, 32'h0000_0000, 32'h0000_2000));
      directed_rows.push_back(pos_row(32'h7FFF_8000, 32'h8000_8000, 32'hFFFF_0001));
      directed_rows.push_back(pos_row(32'h1234_5678, 32'hEDCB_A987, 32'h0F0F_0F0F));
      directed_rows.push_back(pos_row(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
      directed_rows.push_back(pos_row(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));

      // reset held from the start, then released on a falling edge
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_position(directed_rows[i]);
      hold_until_drained();

      // random part, with one quiet stretch and one more hold-off
      for (int i = 0; i < N_RANDOM; i++) begin
         quiet = (i >= QUIET_FROM && i < QUIET_TO);
         if (i == HOLD_AT) hold_until_drained();
         r = pos_row(rand_coord(), rand_coord(), rand_coord());
         send_position(r);
      end

      start <= 1'b0;
      waited = 0;
      while (corner_q.size() != 0 && waited < DRAIN_MAX) begin
         @(posedge clock);
         waited++;
      end
      // let any stray beat show up before the verdict
      repeat (TAIL) @(posedge clock);
      if (corner_q.size() != 0)
         report_mismatch("corners never delivered", corner_q.size(), 0);

      $display("tb: %0d positions, %0d corner beats compared", n_pos, n_beats);
      $display("tb: %0d exactly on the grid, %0d with a negative axis", n_grid, n_negative);
      if (n_errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
design/tcw_pkg.sv
design/trilinear_corner_weights_unit.sv
bench/tb.sv
